FILE: rtl/sobel_edge_magnitude_rgb_assert.svh
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sem assertion failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sem assertion failed");

`endif

FILE: rtl/sem_pkg.sv
// shared constants and types for the sobel edge magnitude block
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int ROW_W     = FH_W + 1;
  localparam int PEND_W    = 11;
  localparam int PIX_W     = 24;
  localparam int GRAD_W    = 11;
  localparam int SUM_W     = 21;

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] WIDTH_LIMIT  = FW_W'(MAX_WIDTH);
  localparam logic [SUM_W-1:0] ROOT_SAT    = SUM_W'(65280);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_ROOT,
    ST_HOLD
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_SQ,
    RT_STEP,
    RT_ROUND
  } root_state_t;

endpackage

FILE: rtl/sem_ram.sv
// generic simple dual port ram with registered read
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sem_root.sv
// gradient square sum and bit-serial rounded square root, one channel
module sem_root (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [sem_pkg::GRAD_W-1:0] gx,
  input  logic signed [sem_pkg::GRAD_W-1:0] gy,
  output logic                              done,
  output logic [7:0]                        root
);

  sem_pkg::root_state_t state, state_next;
  logic [sem_pkg::SUM_W-1:0] sum;
  logic [2:0]                bit_idx;
  logic signed [2*sem_pkg::GRAD_W-1:0] sq_x, sq_y;
  logic [7:0]  trial;
  logic [15:0] trial_sq;
  logic [16:0] round_lim;

  assign sq_x      = gx * gx;
  assign sq_y      = gy * gy;
  assign trial     = root | (8'd1 << bit_idx);
  assign trial_sq  = trial * trial;
  assign round_lim = 17'(root * root) + 17'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::RT_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == sem_pkg::RT_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sem_pkg::RT_SQ: begin
        sum     <= sq_x[sem_pkg::SUM_W-1:0] + sq_y[sem_pkg::SUM_W-1:0];
        root    <= 8'd0;
        bit_idx <= 3'd7;
      end
      sem_pkg::RT_STEP: begin
        if (sem_pkg::SUM_W'(trial_sq) <= sum) begin
          root <= trial;
        end
        bit_idx <= bit_idx - 3'd1;
      end
      sem_pkg::RT_ROUND: begin
        if (sum > sem_pkg::ROOT_SAT) begin
          root <= 8'd255;
        end else if (sum > sem_pkg::SUM_W'(round_lim)) begin
          root <= root + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sem_pkg::RT_IDLE:  if (start) state_next = sem_pkg::RT_SQ;
      sem_pkg::RT_SQ:    state_next = sem_pkg::RT_STEP;
      sem_pkg::RT_STEP:  if (bit_idx == 3'd0) state_next = sem_pkg::RT_ROUND;
      sem_pkg::RT_ROUND: state_next = sem_pkg::RT_IDLE;
      default:           state_next = sem_pkg::RT_IDLE;
    endcase
  end

endmodule

FILE: rtl/sobel_edge_magnitude_rgb.sv
// top level of the streaming rgb sobel edge magnitude block
//
//  channel | signals                                   | dir
//  input   | in_valid in_ready command pixel_*         | in
//  output  | out_valid out_ready edge_* frame_end      | out
//  config  | psel penable pwrite paddr pwdata prdata   | in/out
//
// an item that yields a result passes through: line store read at accept,
// window update and store write-back, square sum, 8 root bit steps, rounding,
// load into the output register, waiting in hold while that register is blocked
// an item without a result ends after the window update; an ignored drain tick leaves control idle
// the next item is accepted while a result still waits in the output register
// reset clears counters and window and sets config to 640 by 480; line stores need no clearing
module sobel_edge_magnitude_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  pixel_blue,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_blue,
  output logic [7:0]  edge_green,
  output logic [7:0]  edge_red,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = sem_pkg::COL_W;
  localparam int RW = sem_pkg::ROW_W;

  sem_pkg::ctrl_state_t state, state_next;

  // configuration
  logic [sem_pkg::FW_W-1:0] frame_width;
  logic [sem_pkg::FH_W-1:0] frame_height;
  logic [sem_pkg::FW_W-1:0] eff_w;
  logic [sem_pkg::FH_W-1:0] eff_h;
  logic cfg_wr;

  // stream state
  logic [CW-1:0]             column;
  logic [RW-1:0]             row;
  logic [sem_pkg::PEND_W-1:0] pending;
  logic [sem_pkg::PIX_W-1:0] window [9];
  logic                      drain_q;
  logic [sem_pkg::PIX_W-1:0] pix_q;
  logic                      last_q;

  // accept path
  logic accept, ignore_item, restart;
  logic [CW-1:0] rd_addr;
  logic [sem_pkg::PIX_W-1:0] up_rd, mid_rd;

  // update path
  logic [sem_pkg::PIX_W-1:0] win_new [9];
  logic [sem_pkg::PIX_W-1:0] taps [9];
  logic [sem_pkg::FW_W-1:0]  col_inc, cc;
  logic [RW-1:0]             cr, row_inc;
  logic                      has, wrap;
  logic [CW-1:0]             col_next;
  logic [RW-1:0]             row_next;
  logic [sem_pkg::PEND_W-1:0] pend_next;
  logic                      last_next;
  logic signed [sem_pkg::GRAD_W-1:0] gx [3];
  logic signed [sem_pkg::GRAD_W-1:0] gy [3];
  logic signed [sem_pkg::GRAD_W-1:0] gx_q [3];
  logic signed [sem_pkg::GRAD_W-1:0] gy_q [3];

  // root units
  logic       root_start;
  logic [2:0] root_done;
  logic [7:0] root [3];
  logic       load_out;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == sem_pkg::REG_HEIGHT) ? 32'(frame_height) : 32'(frame_width);
  assign eff_w    = (frame_width == '0) ? sem_pkg::FW_W'(1) :
                    (frame_width > sem_pkg::WIDTH_LIMIT) ? sem_pkg::WIDTH_LIMIT : frame_width;
  assign eff_h    = (frame_height == '0) ? sem_pkg::FH_W'(1) : frame_height;

  assign in_ready    = (state == sem_pkg::ST_IDLE);
  assign accept      = in_valid && in_ready;
  // drain tick with nothing owed changes nothing
  assign ignore_item = (command == sem_pkg::CMD_DRAIN) && (pending == '0);
  // pixel arriving while results are owed starts a new frame
  assign restart     = (command == sem_pkg::CMD_PIXEL) && (pending != '0);
  assign rd_addr     = restart ? '0 : column;

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (state == sem_pkg::ST_UPD),
    .waddr (column),
    .wdata (mid_rd),
    .re    (accept && !ignore_item),
    .raddr (rd_addr),
    .rdata (up_rd)
  );

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (state == sem_pkg::ST_UPD),
    .waddr (column),
    .wdata (pix_q),
    .re    (accept && !ignore_item),
    .raddr (rd_addr),
    .rdata (mid_rd)
  );

  // window shift, tap selection, border masking and kernels
  always_comb begin
    logic [7:0] t [9];
    for (int m = 0; m < 3; m++) begin
      win_new[m*3]   = window[m*3+1];
      win_new[m*3+1] = window[m*3+2];
    end
    win_new[2] = up_rd;
    win_new[5] = mid_rd;
    win_new[8] = pix_q;

    has = 1'b0;
    cr  = '0;
    cc  = '0;
    for (int k = 0; k < 9; k++) taps[k] = win_new[k];
    if (column != '0) begin
      if (row != '0) begin
        has = 1'b1;
        cr  = row - RW'(1);
        cc  = sem_pkg::FW_W'(column) - sem_pkg::FW_W'(1);
      end
    end else if (row >= RW'(2)) begin
      // first column of a row closes the previous row's last pixel
      has = 1'b1;
      cr  = row - RW'(2);
      cc  = eff_w - sem_pkg::FW_W'(1);
      for (int m = 0; m < 3; m++) begin
        taps[m*3]   = window[m*3+1];
        taps[m*3+1] = window[m*3+2];
        taps[m*3+2] = '0;
      end
    end
    if (cc == '0) begin
      for (int m = 0; m < 3; m++) taps[m*3] = '0;
    end
    if (cr == '0) begin
      for (int n = 0; n < 3; n++) taps[n] = '0;
    end
    if ((RW+1)'(cr) + (RW+1)'(1) >= (RW+1)'(eff_h)) begin
      for (int n = 0; n < 3; n++) taps[6+n] = '0;
    end

    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 9; k++) t[k] = taps[k][c*8 +: 8];
      gx[c] = $signed({3'b000, t[2]}) - $signed({3'b000, t[0]})
            + $signed({2'b00, t[5], 1'b0}) - $signed({2'b00, t[3], 1'b0})
            + $signed({3'b000, t[8]}) - $signed({3'b000, t[6]});
      gy[c] = $signed({3'b000, t[6]}) - $signed({3'b000, t[0]})
            + $signed({2'b00, t[7], 1'b0}) - $signed({2'b00, t[1], 1'b0})
            + $signed({3'b000, t[8]}) - $signed({3'b000, t[2]});
    end

    // raster position and drain bookkeeping
    col_inc  = sem_pkg::FW_W'(column) + sem_pkg::FW_W'(1);
    wrap     = col_inc >= eff_w;
    row_inc  = row + RW'(1);
    col_next = wrap ? '0 : col_inc[CW-1:0];
    row_next = wrap ? row_inc : row;
    pend_next = pending;
    last_next = 1'b0;
    if (drain_q) begin
      pend_next = pending - sem_pkg::PEND_W'(1);
      if (pend_next == '0) begin
        last_next = 1'b1;
        col_next  = '0;
        row_next  = '0;
      end
    end else if (row_next >= RW'(eff_h)) begin
      pend_next = sem_pkg::PEND_W'(eff_w) + sem_pkg::PEND_W'(1);
    end
  end

  assign root_start = (state == sem_pkg::ST_UPD) && has;
  assign load_out   = ((state == sem_pkg::ST_ROOT && root_done[0]) ||
                       state == sem_pkg::ST_HOLD) && (!out_valid || out_ready);

  for (genvar c = 0; c < 3; c++) begin : g_root
    sem_root u_root (
      .clk   (clk),
      .rst   (rst),
      .start (root_start),
      .gx    (gx_q[c]),
      .gy    (gy_q[c]),
      .done  (root_done[c]),
      .root  (root[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sem_pkg::ST_IDLE;
      frame_width  <= sem_pkg::WIDTH_RESET;
      frame_height <= sem_pkg::HEIGHT_RESET;
      column       <= '0;
      row          <= '0;
      pending      <= '0;
      out_valid    <= 1'b0;
      for (int k = 0; k < 9; k++) window[k] <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        // a config write restarts the stream, line stores are kept
        if (paddr[2] == sem_pkg::REG_WIDTH) begin
          frame_width <= pwdata[sem_pkg::FW_W-1:0];
        end else begin
          frame_height <= pwdata[sem_pkg::FH_W-1:0];
        end
        column  <= '0;
        row     <= '0;
        pending <= '0;
        for (int k = 0; k < 9; k++) window[k] <= '0;
      end else if (accept && restart) begin
        column  <= '0;
        row     <= '0;
        pending <= '0;
        for (int k = 0; k < 9; k++) window[k] <= '0;
      end else if (state == sem_pkg::ST_UPD) begin
        column  <= col_next;
        row     <= row_next;
        pending <= pend_next;
        for (int k = 0; k < 9; k++) window[k] <= win_new[k];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      drain_q <= command;
      pix_q   <= (command == sem_pkg::CMD_DRAIN) ? '0 : {pixel_red, pixel_green, pixel_blue};
    end
    if (state == sem_pkg::ST_UPD) begin
      last_q <= last_next;
      gx_q   <= gx;
      gy_q   <= gy;
    end
    if (load_out) begin
      edge_blue  <= root[0];
      edge_green <= root[1];
      edge_red   <= root[2];
      frame_end  <= last_q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sem_pkg::ST_IDLE: if (accept && !ignore_item) state_next = sem_pkg::ST_UPD;
      sem_pkg::ST_UPD:  state_next = has ? sem_pkg::ST_ROOT : sem_pkg::ST_IDLE;
      sem_pkg::ST_ROOT: begin
        if (root_done[0]) state_next = load_out ? sem_pkg::ST_IDLE : sem_pkg::ST_HOLD;
      end
      sem_pkg::ST_HOLD: if (load_out) state_next = sem_pkg::ST_IDLE;
      default:          state_next = sem_pkg::ST_IDLE;
    endcase
  end

`include "sobel_edge_magnitude_rgb_assert.svh"

  // update cycle follows an accepted item
  `SEM_ASSERT_NOW(a_upd_after_accept, state == sem_pkg::ST_UPD, $past(accept))
  // root units finish together and only while awaited
  `SEM_ASSERT_NOW(a_root_done, root_done != 3'b000, root_done == 3'b111 && state == sem_pkg::ST_ROOT)
  // a blocked result parks in hold
  `SEM_ASSERT_NEXT(a_hold, state == sem_pkg::ST_ROOT && root_done[0] && out_valid && !out_ready,
                   state == sem_pkg::ST_HOLD)

endmodule

FILE: verif/sobel_edge_magnitude_rgb_tb.sv
// testbench for the streaming rgb sobel edge magnitude block
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_tb;

  // predicts edge results from accepted items and checks them in order
  class edge_scoreboard;
    typedef struct {
      bit [7:0] blue;
      bit [7:0] green;
      bit [7:0] red;
      bit       last;
    } edge_t;

    edge_t                   owed[$];
    int                      errors;
    bit [sem_pkg::FW_W-1:0]  width_reg;
    bit [sem_pkg::FH_W-1:0]  height_reg;
    bit [sem_pkg::PIX_W-1:0] upper[sem_pkg::MAX_WIDTH];
    bit [sem_pkg::PIX_W-1:0] middle[sem_pkg::MAX_WIDTH];
    bit [sem_pkg::PIX_W-1:0] win[9];
    int                      col;
    int                      row;
    int                      pend;

    function new();
      width_reg  = sem_pkg::WIDTH_RESET;
      height_reg = sem_pkg::HEIGHT_RESET;
      errors     = 0;
      foreach (upper[i]) begin
        upper[i]  = '0;
        middle[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      foreach (win[i]) win[i] = '0;
      col  = 0;
      row  = 0;
      pend = 0;
    endfunction

    function void write_reg(logic idx, bit [31:0] value);
      if (idx == sem_pkg::REG_WIDTH) width_reg = value[sem_pkg::FW_W-1:0];
      else height_reg = value[sem_pkg::FH_W-1:0];
      restart();
    endfunction

    // exact rounded square root, saturated
    function int rounded_root(int s);
      int r;
      r = 0;
      if (s > 65280) return 255;
      for (int b = 128; b != 0; b >>= 1)
        if ((r + b) * (r + b) <= s) r += b;
      if (s > r * r + r) r++;
      return r;
    endfunction

    function bit [7:0] channel_mag(bit [sem_pkg::PIX_W-1:0] t[3][3], int sh);
      int v[3][3];
      int gx;
      int gy;
      foreach (v[m, n]) v[m][n] = (t[m][n] >> sh) & 8'hff;
      gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
      gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
      return 8'(rounded_root(gx * gx + gy * gy));
    endfunction

    function void note_item(logic cmd, bit [7:0] b, bit [7:0] g, bit [7:0] r);
      int                      w;
      int                      h;
      int                      ci;
      int                      ri;
      int                      cr;
      int                      cc;
      bit                      has;
      bit                      last;
      bit [sem_pkg::PIX_W-1:0] pix;
      bit [sem_pkg::PIX_W-1:0] up;
      bit [sem_pkg::PIX_W-1:0] mid;
      bit [sem_pkg::PIX_W-1:0] old[9];
      bit [sem_pkg::PIX_W-1:0] t[3][3];
      edge_t                   e;
      w = (width_reg == 0) ? 1 :
          ((width_reg > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      has  = 0;
      last = 0;
      pix  = '0;
      up   = '0;
      mid  = '0;
      cr   = 0;
      cc   = 0;
      if (cmd == sem_pkg::CMD_DRAIN) begin
        if (pend == 0) return;
      end else begin
        if (pend != 0) restart();
        pix = {r, g, b};
      end
      ci  = col;
      ri  = row;
      old = win;
      if (ci < sem_pkg::MAX_WIDTH) begin
        up         = upper[ci];
        mid        = middle[ci];
        upper[ci]  = mid;
        middle[ci] = pix;
      end
      for (int m = 0; m < 3; m++) begin
        win[m * 3]     = win[m * 3 + 1];
        win[m * 3 + 1] = win[m * 3 + 2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = pix;
      if (ci >= 1) begin
        if (ri >= 1) begin
          has = 1;
          cr  = ri - 1;
          cc  = ci - 1;
          foreach (t[m, n]) t[m][n] = win[m * 3 + n];
        end
      end else if (ri >= 2) begin
        // first column of a row closes the previous row's last pixel
        has = 1;
        cr  = ri - 2;
        cc  = w - 1;
        for (int m = 0; m < 3; m++) begin
          t[m][0] = old[m * 3 + 1];
          t[m][1] = old[m * 3 + 2];
          t[m][2] = '0;
        end
      end
      ci++;
      if (ci >= w) begin
        ci = 0;
        ri++;
      end
      col = ci;
      row = ri;
      if (cmd == sem_pkg::CMD_DRAIN) begin
        pend--;
        if (pend == 0) begin
          last = 1;
          col  = 0;
          row  = 0;
        end
      end else if (ri >= h) begin
        pend = w + 1;
      end
      if (!has) return;
      // taps outside the frame are zero
      if (cc == 0) for (int m = 0; m < 3; m++) t[m][0] = '0;
      if (cr == 0) for (int m = 0; m < 3; m++) t[0][m] = '0;
      if (cr + 1 >= h) for (int m = 0; m < 3; m++) t[2][m] = '0;
      e.blue  = channel_mag(t, 0);
      e.green = channel_mag(t, 8);
      e.red   = channel_mag(t, 16);
      e.last  = last;
      owed.push_back(e);
    endfunction

    function void check_result(bit [7:0] b, bit [7:0] g, bit [7:0] r, bit fe);
      edge_t e;
      if (owed.size() == 0) begin
        $error("edge result with nothing expected");
        errors++;
        return;
      end
      e = owed.pop_front();
      if (b != e.blue) begin
        $error("edge_blue expected %0d actual %0d", e.blue, b);
        errors++;
      end
      if (g != e.green) begin
        $error("edge_green expected %0d actual %0d", e.green, g);
        errors++;
      end
      if (r != e.red) begin
        $error("edge_red expected %0d actual %0d", e.red, r);
        errors++;
      end
      if (fe != e.last) begin
        $error("frame_end expected %0d actual %0d", e.last, fe);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [7:0]  pixel_blue;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_red;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  edge_blue;
  logic [7:0]  edge_green;
  logic [7:0]  edge_red;
  logic        frame_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  edge_scoreboard edges = new();
  int send_idle_pct;   // sender gap chance per item, percent
  int recv_idle_pct;   // receiver stall chance per cycle, percent
  int items_sent;

  sobel_edge_magnitude_rgb i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .pixel_blue (pixel_blue),
    .pixel_green(pixel_green),
    .pixel_red  (pixel_red),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_blue  (edge_blue),
    .edge_green (edge_green),
    .edge_red   (edge_red),
    .frame_end  (frame_end),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // results are taken and checked at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      edges.check_result(edge_blue, edge_green, edge_red, frame_end);
  end

  // run limit, far above the slowest correct run
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // one item through the input handshake; starts and ends at a falling edge
  task automatic send_item(logic cmd, bit [7:0] b, bit [7:0] g, bit [7:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    pixel_blue  <= b;
    pixel_green <= g;
    pixel_red   <= r;
    do @(posedge clk); while (!in_ready);
    edges.note_item(cmd, b, g, r);
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input off until every owed result is out and the block is quiet
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (edges.owed.size() != 0) @(negedge clk);
    // a result-less item may still be in flight
    repeat (20) @(negedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(logic idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    edges.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame(bit [31:0] w, bit [31:0] h);
    wait_quiet();
    write_reg(sem_pkg::REG_WIDTH, w);
    write_reg(sem_pkg::REG_HEIGHT, h);
  endtask

  // pixel content: mostly random, sometimes full-scale to drive saturation
  task automatic send_pixel();
    if ($urandom_range(9) < 3)
      send_item(sem_pkg::CMD_PIXEL, {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                {8{1'($urandom_range(1))}});
    else
      send_item(sem_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a frame of pixels, then drain ticks unless the frame is cut short
  task automatic run_frame(int w, int h, bit complete);
    int npix;
    npix = complete ? w * h : $urandom_range(w * h);
    for (int i = 0; i < npix; i++) begin
      // stray drain tick while the frame arrives, ignored
      if ($urandom_range(99) < 3)
        send_item(sem_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    if (complete) begin
      for (int i = 0; i < w + 1; i++)
        send_item(sem_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0) send_item(sem_pkg::CMD_DRAIN, 8'hff, 8'hff, 8'hff);
    end
  endtask

  initial begin
    int w;
    int h;
    int wait_cycles;
    rst           = 1'b1;
    in_valid      = 1'b0;
    command       = sem_pkg::CMD_PIXEL;
    pixel_blue    = '0;
    pixel_green   = '0;
    pixel_red     = '0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 12;
    recv_idle_pct = 84;
    items_sent    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 3x3 frame of extremes with stray and extra drain ticks
    set_frame(3, 3);
    send_item(sem_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    send_item(sem_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h00);
    send_item(sem_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'hff);
    send_item(sem_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h00);
    send_item(sem_pkg::CMD_DRAIN, 8'hff, 8'hff, 8'hff);
    send_item(sem_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'hff);
    send_item(sem_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h00);
    send_item(sem_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'hff);
    send_item(sem_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(sem_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(sem_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 5; i++) send_item(sem_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    // zero sizes count as one: single-pixel frame
    set_frame(0, 0);
    send_item(sem_pkg::CMD_PIXEL, 8'h80, 8'h7f, 8'h01);
    send_item(sem_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    // new frame while results are still owed abandons them
    send_item(sem_pkg::CMD_PIXEL, 8'hfe, 8'h01, 8'h55);
    send_item(sem_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    send_item(sem_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    // tallest frame, cut short
    set_frame(1, 4095);
    for (int i = 0; i < 4; i++) send_pixel();

    // random frames, mostly small, across the three idling phases
    while (items_sent < 220) begin
      if (items_sent > 75) begin
        send_idle_pct = 84;
        recv_idle_pct = 12;
      end
      if (items_sent > 150) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      h = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      set_frame(w, h);
      run_frame(w, h, $urandom_range(9) != 0);
    end

    // widest frame: width above the limit saturates, cut short after the row wraps
    set_frame(2047, 2);
    for (int i = 0; i < 1030; i++) send_pixel();

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (edges.owed.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (edges.owed.size() != 0) begin
      $error("%0d edge results never arrived", edges.owed.size());
      edges.errors++;
    end
    repeat (40) @(posedge clk);
    if (edges.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_root.sv
rtl/sobel_edge_magnitude_rgb.sv
verif/sobel_edge_magnitude_rgb_tb.sv
